>>> design/conv2d_sliding_window_assert.svh
// Assertion macros for the checker of the convolution block.
`ifndef CONV2D_SLIDING_WINDOW_ASSERT_SVH
`define CONV2D_SLIDING_WINDOW_ASSERT_SVH

// Checked only while out of reset.
`define C2DSW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked during reset as well.
`define C2DSW_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/c2dsw_pkg.sv
// Types, constants and helper functions of the 3x3 convolution block.
package c2dsw_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int WIDTH_CAP  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int KSIZE      = 3;
  localparam int PIXEL_BITS = 16;
  localparam int PROD_W     = 2 * PIXEL_BITS;
  localparam int ROWSUM_W   = PROD_W + 2;
  localparam int SUM_W      = 36;
  localparam int IDX_W      = 10;
  localparam int DIM_W      = 11;
  localparam int STRIDE_W   = 3;
  localparam int COEF_W     = 48;
  localparam int CFG_IDX_W  = 4;
  localparam int DIM_MIN    = 3;
  localparam int STRIDE_MAX = 4;
  localparam int RECIP3     = 683;
  localparam int RECIP3_SH  = 11;
  localparam int QPROD_W    = DIM_W + RECIP3_SH - 1;
  localparam int NCOMBO     = 4;

  localparam logic MODE_VALID = 1'b0;
  localparam logic MODE_SAME  = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH    = 4'd0,
    REG_HEIGHT   = 4'd1,
    REG_PADDING  = 4'd2,
    REG_RSTRIDE  = 4'd3,
    REG_CSTRIDE  = 4'd4,
    REG_COEF_TOP = 4'd5,
    REG_COEF_MID = 4'd6,
    REG_COEF_BOT = 4'd7
  } cfg_reg_t;

  typedef logic signed [PIXEL_BITS-1:0] pix_t;
  typedef logic signed [PROD_W-1:0]     prod_t;
  typedef logic signed [ROWSUM_W-1:0]   rowsum_t;
  typedef logic signed [SUM_W-1:0]      sum_t;
  typedef pix_t col_t [KSIZE];
  typedef pix_t win_t [KSIZE][KSIZE];

  typedef struct packed {
    logic [IDX_W-1:0] orow;
    logic [IDX_W-1:0] ocol;
    logic             last;
    logic             eof;
  } meta_t;

  typedef struct packed {
    logic [NCOMBO-1:0] mask;
    logic [IDX_W-1:0]  orow_a;
    logic [IDX_W-1:0]  orow_b;
    logic [IDX_W-1:0]  ocol_a;
    logic [IDX_W-1:0]  ocol_b;
    logic              eofr_a;
    logic              eofr_b;
    logic              eofc_a;
    logic              eofc_b;
    logic              zr0;
    logic              zc0;
  } desc_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    if (v < DIM_W'(DIM_MIN)) return DIM_W'(DIM_MIN);
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [STRIDE_W-1:0] clamp_stride(input logic [STRIDE_W-1:0] s);
    if (s == '0) return STRIDE_W'(1);
    if (s > STRIDE_W'(STRIDE_MAX)) return STRIDE_W'(STRIDE_MAX);
    return s;
  endfunction

  // quotient by a stride of 1..4; thirds by reciprocal, exact below 1024
  function automatic logic [IDX_W-1:0] qdiv(input logic [DIM_W-1:0] x,
                                            input logic [STRIDE_W-1:0] s);
    logic [QPROD_W-1:0] p;
    p = QPROD_W'(x) * QPROD_W'(RECIP3);
    case (s)
      3'd2:    return x[IDX_W:1];
      3'd3:    return p[RECIP3_SH +: IDX_W];
      3'd4:    return IDX_W'(x[DIM_W-1:2]);
      default: return x[IDX_W-1:0];
    endcase
  endfunction

  function automatic logic divisible(input logic [DIM_W-1:0] x,
                                     input logic [STRIDE_W-1:0] s);
    logic [DIM_W:0] back;
    back = (DIM_W+1)'(qdiv(x, s)) * (DIM_W+1)'(s);
    return back == (DIM_W+1)'(x);
  endfunction

endpackage

>>> design/conv2d_sliding_window.sv
// Top level of the streaming 3x3 strided convolution block.
//
// Pixels enter on in_valid/in_ready in raster order, one word per cycle while in_ready is high.
// Each pixel yields zero to four result words on out_valid/out_ready, in
// ascending row then column order; last_in_run marks the final word of a
// pixel and end_of_frame the final window of the image.
// Configuration is written through cfg_valid/cfg_index/cfg_data while the
// block is idle, which the block itself does not enforce; cfg_ready is always high.
// A pixel passes the stage 1 and stage 2 registers, then the product, row sum
// and output registers of the multiply unit. Throughput is one pixel per cycle
// while nothing stalls; a pixel with more than one result holds the input until
// its last window issues, as the single multiply unit takes one window per cycle.
// Line store: one 2 x 16 bit word per column, read when a pixel is taken and
// written when that pixel leaves stage 1.
// Reset returns the registers to 64 x 64, VALID, stride 1, zero kernel, and
// the position to the top-left pixel. No clearing pass is needed.
// A stalled receiver fills the output, product and sum stages; the input
// keeps taking pixels until all stages are full.
module conv2d_sliding_window (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [c2dsw_pkg::PIXEL_BITS-1:0] in_pixel,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [c2dsw_pkg::SUM_W-1:0]      out_sum,
  output logic [c2dsw_pkg::IDX_W-1:0]             out_row,
  output logic [c2dsw_pkg::IDX_W-1:0]             out_col,
  output logic                                    out_last_in_run,
  output logic                                    out_end_of_frame,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [c2dsw_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [c2dsw_pkg::COEF_W-1:0]            cfg_data
);

  localparam int PB = c2dsw_pkg::PIXEL_BITS;
  localparam int DW = c2dsw_pkg::DIM_W;
  localparam int IW = c2dsw_pkg::IDX_W;
  localparam int K  = c2dsw_pkg::KSIZE;

  // configuration
  logic [DW-1:0]                     width_r, height_r;
  logic                              mode_r;
  logic [c2dsw_pkg::STRIDE_W-1:0]    rstride_r, cstride_r;
  logic [c2dsw_pkg::COEF_W-1:0]      coef_r [K];
  logic [DW-1:0]                     w_c, h_c, w_m1, h_m1;
  logic [c2dsw_pkg::STRIDE_W-1:0]    rs, cs;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= DW'(64);
      height_r  <= DW'(64);
      mode_r    <= c2dsw_pkg::MODE_VALID;
      rstride_r <= c2dsw_pkg::STRIDE_W'(1);
      cstride_r <= c2dsw_pkg::STRIDE_W'(1);
      coef_r    <= '{default: '0};
    end else if (cfg_valid) begin
      unique case (c2dsw_pkg::cfg_reg_t'(cfg_index))
        c2dsw_pkg::REG_WIDTH:    width_r   <= cfg_data[DW-1:0];
        c2dsw_pkg::REG_HEIGHT:   height_r  <= cfg_data[DW-1:0];
        c2dsw_pkg::REG_PADDING:  mode_r    <= cfg_data[0];
        c2dsw_pkg::REG_RSTRIDE:  rstride_r <= cfg_data[c2dsw_pkg::STRIDE_W-1:0];
        c2dsw_pkg::REG_CSTRIDE:  cstride_r <= cfg_data[c2dsw_pkg::STRIDE_W-1:0];
        c2dsw_pkg::REG_COEF_TOP: coef_r[0] <= cfg_data;
        c2dsw_pkg::REG_COEF_MID: coef_r[1] <= cfg_data;
        c2dsw_pkg::REG_COEF_BOT: coef_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_c  = c2dsw_pkg::clamp_dim(width_r, DW'(c2dsw_pkg::WIDTH_CAP));
  assign h_c  = c2dsw_pkg::clamp_dim(height_r, DW'(c2dsw_pkg::MAX_HEIGHT));
  assign w_m1 = w_c - DW'(1);
  assign h_m1 = h_c - DW'(1);
  assign rs   = c2dsw_pkg::clamp_stride(rstride_r);
  assign cs   = c2dsw_pkg::clamp_stride(cstride_r);

  // position of the next pixel
  logic [IW-1:0] row_cnt_r, row_cnt_nxt, col_cnt_r, col_cnt_nxt, r0, c0;
  logic          acc;

  assign r0  = ({1'b0, row_cnt_r} < h_c) ? row_cnt_r : h_m1[IW-1:0];
  assign c0  = ({1'b0, col_cnt_r} < w_c) ? col_cnt_r : w_m1[IW-1:0];
  assign acc = in_valid && in_ready;

  always_comb begin
    if ({1'b0, c0} == w_m1) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = ({1'b0, r0} == h_m1) ? '0 : r0 + IW'(1);
    end else begin
      col_cnt_nxt = c0 + IW'(1);
      row_cnt_nxt = r0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      col_cnt_r <= '0;
    end else if (acc) begin
      row_cnt_r <= row_cnt_nxt;
      col_cnt_r <= col_cnt_nxt;
    end
  end

  // stage 1: pixel with its line store word
  logic            s1_v_r, s1_free, s1_mv, s2_free;
  c2dsw_pkg::pix_t p1_r;
  logic [IW-1:0]   r1_r, c1_r;
  logic [2*PB-1:0] line_mem [c2dsw_pkg::MAX_WIDTH];
  logic [2*PB-1:0] rd_r;

  assign s1_free  = !s1_v_r || s2_free;
  assign s1_mv    = s1_v_r && s2_free;
  assign in_ready = s1_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      p1_r <= in_pixel;
      r1_r <= r0;
      c1_r <= c0;
      rd_r <= line_mem[c2dsw_pkg::ADDR_W'(c0)];
    end
    if (s1_mv) begin
      line_mem[c2dsw_pkg::ADDR_W'(c1_r)] <= {p1_r, rd_r[2*PB-1:PB]};
    end
  end

  // result descriptor of the pixel in stage 1
  c2dsw_pkg::desc_t desc_nxt, desc_r;
  logic [DW-1:0]    r11, c11;
  logic [IW-1:0]    qr2, qr1, qr0, qh3, qh1, qc2, qc1, qc0, qw3, qw1;
  logic             ra, rb, ca, cb;

  assign r11 = {1'b0, r1_r};
  assign c11 = {1'b0, c1_r};
  assign qr2 = c2dsw_pkg::qdiv(r11 - DW'(2), rs);
  assign qr1 = c2dsw_pkg::qdiv(r11 - DW'(1), rs);
  assign qr0 = c2dsw_pkg::qdiv(r11, rs);
  assign qh3 = c2dsw_pkg::qdiv(h_c - DW'(3), rs);
  assign qh1 = c2dsw_pkg::qdiv(h_m1, rs);
  assign qc2 = c2dsw_pkg::qdiv(c11 - DW'(2), cs);
  assign qc1 = c2dsw_pkg::qdiv(c11 - DW'(1), cs);
  assign qc0 = c2dsw_pkg::qdiv(c11, cs);
  assign qw3 = c2dsw_pkg::qdiv(w_c - DW'(3), cs);
  assign qw1 = c2dsw_pkg::qdiv(w_m1, cs);

  always_comb begin
    desc_nxt = '0;
    ra = 1'b0;
    rb = 1'b0;
    ca = 1'b0;
    cb = 1'b0;
    if (mode_r == c2dsw_pkg::MODE_VALID) begin
      ra = (r11 >= DW'(2)) && c2dsw_pkg::divisible(r11 - DW'(2), rs);
      ca = (c11 >= DW'(2)) && c2dsw_pkg::divisible(c11 - DW'(2), cs);
      desc_nxt.orow_a = qr2;
      desc_nxt.ocol_a = qc2;
      desc_nxt.eofr_a = (qr2 == qh3);
      desc_nxt.eofc_a = (qc2 == qw3);
    end else begin
      ra = (r11 >= DW'(1)) && c2dsw_pkg::divisible(r11 - DW'(1), rs);
      rb = (r11 == h_m1) && c2dsw_pkg::divisible(r11, rs);
      ca = (c11 >= DW'(1)) && c2dsw_pkg::divisible(c11 - DW'(1), cs);
      cb = (c11 == w_m1) && c2dsw_pkg::divisible(c11, cs);
      desc_nxt.orow_a = qr1;
      desc_nxt.orow_b = qr0;
      desc_nxt.ocol_a = qc1;
      desc_nxt.ocol_b = qc0;
      desc_nxt.eofr_a = (qr1 == qh1);
      desc_nxt.eofr_b = 1'b1;
      desc_nxt.eofc_a = (qc1 == qw1);
      desc_nxt.eofc_b = 1'b1;
      desc_nxt.zr0    = (r11 == DW'(1));
      desc_nxt.zc0    = (c11 == DW'(1));
    end
    desc_nxt.mask = {rb & cb, rb & ca, ra & cb, ra & ca};
  end

  // window: a chain of column cells, newest column at the right end
  c2dsw_pkg::col_t cell_in [K];
  c2dsw_pkg::col_t cell_out [K];
  c2dsw_pkg::col_t new_col;
  c2dsw_pkg::win_t win;

  always_comb begin
    new_col[0] = rd_r[PB-1:0];
    new_col[1] = rd_r[2*PB-1:PB];
    new_col[2] = p1_r;
    for (int k = 0; k < K; k++) begin
      cell_in[k] = (k == K - 1) ? new_col : cell_out[(k + 1) % K];
      for (int x = 0; x < K; x++) begin
        win[x][k] = cell_out[k][x];
      end
    end
  end

  for (genvar g = 0; g < K; g++) begin : g_cell
    c2dsw_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (s1_mv),
      .col_in   (cell_in[g]),
      .col_out  (cell_out[g])
    );
  end

  // stage 2: issue the windows of one pixel, one per cycle while the multiply unit is ready
  logic                           s2_v_r, issue, s2_done, last, u, v, m_ready;
  logic [c2dsw_pkg::NCOMBO-1:0]   rem_r, pick, rest;
  c2dsw_pkg::win_t                view, coef_w;
  c2dsw_pkg::meta_t               meta, o_meta;
  logic                           rok, cok;

  assign pick    = rem_r & (~rem_r + c2dsw_pkg::NCOMBO'(1));
  assign rest    = rem_r & ~pick;
  assign last    = (rest == '0);
  assign u       = pick[2] | pick[3];
  assign v       = pick[1] | pick[3];
  assign issue   = s2_v_r && (rem_r != '0) && m_ready;
  assign s2_done = s2_v_r && ((rem_r == '0) || (last && m_ready));
  assign s2_free = !s2_v_r || s2_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
      rem_r  <= '0;
    end else if (s2_free) begin
      s2_v_r <= s1_v_r;
      rem_r  <= s1_v_r ? desc_nxt.mask : '0;
    end else if (issue) begin
      rem_r <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_mv) desc_r <= desc_nxt;
  end

  always_comb begin
    int xi, yi;
    rok = 1'b0;
    cok = 1'b0;
    for (int x = 0; x < K; x++) begin
      for (int y = 0; y < K; y++) begin
        rok = u ? (x < K - 1) : !(desc_r.zr0 && x == 0);
        cok = v ? (y < K - 1) : !(desc_r.zc0 && y == 0);
        xi = (u && x < K - 1) ? x + 1 : x;
        yi = (v && y < K - 1) ? y + 1 : y;
        view[x][y] = (rok && cok) ? win[xi][yi] : '0;
        coef_w[x][y] = coef_r[x][PB*y +: PB];
      end
    end
    meta.orow = u ? desc_r.orow_b : desc_r.orow_a;
    meta.ocol = v ? desc_r.ocol_b : desc_r.ocol_a;
    meta.last = last;
    meta.eof  = (u ? desc_r.eofr_b : desc_r.eofr_a) && (v ? desc_r.eofc_b : desc_r.eofc_a);
  end

  c2dsw_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (issue),
    .in_ready  (m_ready),
    .pix       (view),
    .coef      (coef_w),
    .meta_in   (meta),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_sum   (out_sum),
    .out_meta  (o_meta)
  );

  assign out_row          = o_meta.orow;
  assign out_col          = o_meta.ocol;
  assign out_last_in_run  = o_meta.last;
  assign out_end_of_frame = o_meta.eof;

endmodule

>>> design/c2dsw_cell.sv
// One window column cell: holds three pixels and passes them on each shift.
module c2dsw_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift_en,
  input  c2dsw_pkg::col_t   col_in,
  output c2dsw_pkg::col_t   col_out
);

  c2dsw_pkg::col_t col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '{default: '0};
    end else if (shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_out = col_r;

endmodule

>>> design/c2dsw_mac.sv
// Nine-tap multiply and adder tree with the result output register.
module c2dsw_mac (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  c2dsw_pkg::win_t     pix,
  input  c2dsw_pkg::win_t     coef,
  input  c2dsw_pkg::meta_t    meta_in,
  output logic                out_valid,
  input  logic                out_ready,
  output c2dsw_pkg::sum_t     out_sum,
  output c2dsw_pkg::meta_t    out_meta
);

  c2dsw_pkg::prod_t   prod_r [c2dsw_pkg::KSIZE][c2dsw_pkg::KSIZE];
  c2dsw_pkg::prod_t   prod_nxt [c2dsw_pkg::KSIZE][c2dsw_pkg::KSIZE];
  c2dsw_pkg::rowsum_t rsum_r [c2dsw_pkg::KSIZE];
  c2dsw_pkg::rowsum_t rsum_nxt [c2dsw_pkg::KSIZE];
  c2dsw_pkg::sum_t    sum_r, sum_nxt;
  c2dsw_pkg::meta_t   m1_meta_r, m2_meta_r, o_meta_r;
  logic               m1_v_r, m2_v_r, o_v_r;
  logic               o_free, m2_free, m1_free;

  assign o_free  = !o_v_r || out_ready;
  assign m2_free = !m2_v_r || o_free;
  assign m1_free = !m1_v_r || m2_free;
  assign in_ready = m1_free;

  always_comb begin
    for (int x = 0; x < c2dsw_pkg::KSIZE; x++) begin
      for (int y = 0; y < c2dsw_pkg::KSIZE; y++) begin
        prod_nxt[x][y] = $signed(pix[x][y]) * $signed(coef[x][y]);
      end
      rsum_nxt[x] = c2dsw_pkg::ROWSUM_W'(prod_r[x][0]) +
                    c2dsw_pkg::ROWSUM_W'(prod_r[x][1]) +
                    c2dsw_pkg::ROWSUM_W'(prod_r[x][2]);
    end
    sum_nxt = c2dsw_pkg::SUM_W'(rsum_r[0]) + c2dsw_pkg::SUM_W'(rsum_r[1]) +
              c2dsw_pkg::SUM_W'(rsum_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (m1_free) m1_v_r <= in_valid;
      if (m2_free) m2_v_r <= m1_v_r;
      if (o_free)  o_v_r  <= m2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (m1_free && in_valid) begin
      prod_r    <= prod_nxt;
      m1_meta_r <= meta_in;
    end
    if (m2_free && m1_v_r) begin
      rsum_r    <= rsum_nxt;
      m2_meta_r <= m1_meta_r;
    end
    if (o_free && m2_v_r) begin
      sum_r    <= sum_nxt;
      o_meta_r <= m2_meta_r;
    end
  end

  assign out_valid = o_v_r;
  assign out_sum   = sum_r;
  assign out_meta  = o_meta_r;

endmodule

>>> design/c2dsw_checker.sv
// Port-level checker for the convolution block, bound to the top level.
`include "conv2d_sliding_window_assert.svh"

module c2dsw_checker (
  input logic                                    clk,
  input logic                                    rst_n,
  input logic                                    in_valid,
  input logic                                    in_ready,
  input logic signed [c2dsw_pkg::PIXEL_BITS-1:0] in_pixel,
  input logic                                    out_valid,
  input logic                                    out_ready,
  input logic signed [c2dsw_pkg::SUM_W-1:0]      out_sum,
  input logic [c2dsw_pkg::IDX_W-1:0]             out_row,
  input logic [c2dsw_pkg::IDX_W-1:0]             out_col,
  input logic                                    out_last_in_run,
  input logic                                    out_end_of_frame,
  input logic                                    cfg_valid,
  input logic                                    cfg_ready,
  input logic [c2dsw_pkg::CFG_IDX_W-1:0]         cfg_index,
  input logic [c2dsw_pkg::COEF_W-1:0]            cfg_data
);

  `C2DSW_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_sum) && $stable(out_row) && $stable(out_col) && $stable(out_end_of_frame), "result word changed while stalled")
  `C2DSW_ASSERT(a_eof_last, out_valid && out_end_of_frame |-> out_last_in_run, "end of frame not on last word of its pixel")
  `C2DSW_ASSERT_RST(a_reset, !rst_n |=> !out_valid && in_ready, "pipeline not empty after reset")
  `C2DSW_ASSERT(a_cfg_ready, cfg_valid |-> cfg_ready, "configuration write refused")

endmodule

bind conv2d_sliding_window c2dsw_checker u_c2dsw_checker (.*);
